[rtl/core/lte_pkg.sv]
// Shared types, register codes and reset values for the LED twinkle pixel engine.
`timescale 1ns / 1ps

package lte_pkg;

    localparam int PICK_COUNT = 4;
    localparam int NUM_PALETTE = 4;
    localparam int CMDQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 8;

    localparam logic [1:0] PICK_MAX = 2'(PICK_COUNT - 1);

    // Register index codes (byte address / 4)
    localparam logic [2:0] REG_PALETTE_0   = 3'd0;
    localparam logic [2:0] REG_PALETTE_1   = 3'd1;
    localparam logic [2:0] REG_PALETTE_2   = 3'd2;
    localparam logic [2:0] REG_PALETTE_3   = 3'd3;
    localparam logic [2:0] REG_MIN_BRIGHT  = 3'd4;
    localparam logic [2:0] REG_MAX_BRIGHT  = 3'd5;
    localparam logic [2:0] REG_BRIGHT_STEP = 3'd6;

    localparam logic [23:0] PALETTE_RESET = 24'h323232;
    localparam logic [7:0]  MIN_RESET     = 8'd1;
    localparam logic [7:0]  MAX_RESET     = 8'd255;
    localparam logic [7:0]  STEP_RESET    = 8'd8;

    typedef struct packed {
        logic [NUM_PALETTE-1:0][23:0] palette;
        logic [7:0]                   start_level;
        logic [7:0]                   peak_level;
        logic [7:0]                   brightness_step;
    } lte_cfg_t;

    typedef struct packed {
        logic       active;
        logic       rising;
        logic [7:0] brightness;
        logic [23:0] color;
    } lte_entry_t;

    localparam lte_entry_t ENTRY_RESET = '{
        active: 1'b0, rising: 1'b1, brightness: 8'd0, color: 24'd0
    };

    // Classified frame update travelling from front to back
    typedef struct packed {
        logic [7:0] pixel;
        logic       spawn;
        logic [1:0] pick;
        logic       in_range;
    } lte_cmd_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } lte_pix_t;

endpackage

[rtl/core/lte_if.sv]
// Valid/ready channel interfaces for pixel updates in and colored pixels out.
`timescale 1ns / 1ps

interface lte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_index;
    logic       spawn_hit;
    logic [1:0] color_pick;

    modport source (output valid, output pixel_index, output spawn_hit, output color_pick,
                    input ready);
    modport sink (input valid, input pixel_index, input spawn_hit, input color_pick,
                  output ready);
endinterface

interface lte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_pixel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output out_pixel, output red, output green, output blue,
                    input ready);
    modport sink (input valid, input out_pixel, input red, input green, input blue,
                  output ready);
endinterface

[rtl/core/lte_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lte_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/lte_fifo.sv]
// Small register-based FIFO with occupancy count.
`timescale 1ns / 1ps

module lte_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           din,
    input  logic                       pop,
    output logic [WIDTH-1:0]           dout,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign count = count_reg;

endmodule

[rtl/core/lte_front.sv]
// Front end: accepts pixel updates, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module lte_front #(
    parameter int NUM_PIXELS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    lte_in_if.sink            pix_in,
    input  logic              clear_busy,
    output logic              cmd_valid,
    output lte_pkg::lte_cmd_t cmd,
    input  logic              cmd_pop
);
    import lte_pkg::*;

    localparam int CMP_W = $clog2(NUM_PIXELS + 1) + 8;

    lte_cmd_t in_cmd;
    logic     cmdq_full;
    logic     cmdq_empty;
    logic     push;

    always_comb
    begin
        in_cmd.pixel    = pix_in.pixel_index;
        in_cmd.spawn    = pix_in.spawn_hit;
        in_cmd.in_range = (CMP_W'(pix_in.pixel_index) < CMP_W'(NUM_PIXELS));
        // palette picks past the last color saturate
        in_cmd.pick     = ({1'b0, pix_in.color_pick} > {1'b0, PICK_MAX}) ? PICK_MAX
                                                                        : pix_in.color_pick;
    end

    assign pix_in.ready = !cmdq_full && !clear_busy;
    assign push         = pix_in.valid && pix_in.ready;

    lte_fifo #(
        .WIDTH ($bits(lte_cmd_t)),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (in_cmd),
        .pop   (cmd_pop),
        .dout  (cmd),
        .empty (cmdq_empty),
        .full  (cmdq_full),
        .count ()
    );

    assign cmd_valid = !cmdq_empty;

endmodule

[rtl/core/lte_back.sv]
// Back end: pixel status read-modify-write, brightness scaling and output queue.
`timescale 1ns / 1ps

module lte_back #(
    parameter int NUM_PIXELS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lte_pkg::lte_cfg_t cfg,
    input  logic              cmd_valid,
    input  lte_pkg::lte_cmd_t cmd,
    output logic              cmd_pop,
    output logic              clear_busy,
    lte_out_if.source         pix_out
);
    import lte_pkg::*;

    localparam int ADDR_W   = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int OQ_CNT_W = $clog2(OUTQ_DEPTH + 1);
    localparam int SUM_W    = OQ_CNT_W + 1;

    // floor(p / 255) for p <= 255*255
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] t;
        t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    // clearing pass
    logic              clear_busy_reg;
    logic [ADDR_W-1:0] clear_addr_reg;

    // pipeline
    logic              s1_valid_reg;
    lte_cmd_t          s1_cmd_reg;
    logic              s2_valid_reg;
    logic [7:0]        s2_pixel_reg;
    logic [7:0]        s2_level_reg;
    logic [23:0]       s2_color_reg;
    logic              s3_valid_reg;
    logic [7:0]        s3_pixel_reg;
    logic [15:0]       s3_red_reg, s3_green_reg, s3_blue_reg;

    // RAM and bypass of the write landing on the same edge as a read
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    lte_entry_t        ram_wdata;
    lte_entry_t        ram_rdata;
    logic              fwd_we_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    lte_entry_t        fwd_data_reg;

    logic [ADDR_W-1:0] s1_addr;
    lte_entry_t        cur;
    lte_entry_t        upd;
    logic [8:0]        sum;

    logic [OQ_CNT_W-1:0] oq_count;
    logic                oq_empty;
    logic                credit_ok;
    lte_pix_t            oq_din;
    lte_pix_t            oq_dout;
    logic                oq_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == ADDR_W'(NUM_PIXELS - 1))
            begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    assign clear_busy = clear_busy_reg;

    // only issue when the output queue is sure to have room for everything in flight
    assign credit_ok = ({1'b0, oq_count} + SUM_W'(s1_valid_reg) + SUM_W'(s2_valid_reg)
                        + SUM_W'(s3_valid_reg)) < SUM_W'(OUTQ_DEPTH);
    assign cmd_pop   = cmd_valid && !clear_busy_reg && credit_ok;

    lte_ram #(
        .WIDTH  ($bits(lte_entry_t)),
        .DEPTH  (NUM_PIXELS),
        .ADDR_W (ADDR_W)
    ) u_status_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ADDR_W'(cmd.pixel)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_addr = ADDR_W'(s1_cmd_reg.pixel);
        cur = (fwd_we_reg && (fwd_addr_reg == s1_addr)) ? fwd_data_reg : ram_rdata;
        upd = cur;
        if (!cur.active && s1_cmd_reg.spawn)
        begin
            upd.active     = 1'b1;
            upd.rising     = 1'b1;
            upd.brightness = cfg.start_level;
            upd.color      = cfg.palette[s1_cmd_reg.pick];
        end
        sum = {1'b0, upd.brightness} + {1'b0, cfg.brightness_step};
        if (upd.active)
        begin
            if (upd.rising)
            begin
                if (sum >= {1'b0, cfg.peak_level})
                begin
                    upd.brightness = cfg.peak_level;
                    upd.rising     = 1'b0;
                end
                else
                begin
                    upd.brightness = sum[7:0];
                end
            end
            else if (upd.brightness <= cfg.brightness_step)
            begin
                upd.brightness = 8'd0;
                upd.active     = 1'b0;
                upd.rising     = 1'b1;
            end
            else
            begin
                upd.brightness = upd.brightness - cfg.brightness_step;
            end
        end
    end

    assign ram_we    = clear_busy_reg || (s1_valid_reg && s1_cmd_reg.in_range);
    assign ram_waddr = clear_busy_reg ? clear_addr_reg : s1_addr;
    assign ram_wdata = clear_busy_reg ? ENTRY_RESET : upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            fwd_we_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd_pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            fwd_we_reg   <= ram_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            s1_cmd_reg <= cmd;
        end
        fwd_addr_reg <= ram_waddr;
        fwd_data_reg <= ram_wdata;
        s2_pixel_reg <= s1_cmd_reg.pixel;
        s2_level_reg <= s1_cmd_reg.in_range ? upd.brightness : 8'd0;
        s2_color_reg <= upd.color;
        s3_pixel_reg <= s2_pixel_reg;
        s3_red_reg   <= 16'(s2_level_reg) * 16'(s2_color_reg[23:16]);
        s3_green_reg <= 16'(s2_level_reg) * 16'(s2_color_reg[15:8]);
        s3_blue_reg  <= 16'(s2_level_reg) * 16'(s2_color_reg[7:0]);
    end

    always_comb
    begin
        oq_din.pixel = s3_pixel_reg;
        oq_din.red   = div255(s3_red_reg);
        oq_din.green = div255(s3_green_reg);
        oq_din.blue  = div255(s3_blue_reg);
    end

    assign oq_pop = pix_out.valid && pix_out.ready;

    lte_fifo #(
        .WIDTH ($bits(lte_pix_t)),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (s3_valid_reg),
        .din   (oq_din),
        .pop   (oq_pop),
        .dout  (oq_dout),
        .empty (oq_empty),
        .full  (),
        .count (oq_count)
    );

    assign pix_out.valid     = !oq_empty;
    assign pix_out.out_pixel = oq_dout.pixel;
    assign pix_out.red       = oq_dout.red;
    assign pix_out.green     = oq_dout.green;
    assign pix_out.blue      = oq_dout.blue;

    a_no_issue_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !clear_busy_reg)
        else $error("status read issued during clearing pass");

    a_outq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (oq_count != OQ_CNT_W'(OUTQ_DEPTH)))
        else $error("output queue overflow");

    a_inactive_is_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && !clear_busy_reg) |->
            (ram_wdata.active || (ram_wdata.brightness == 8'd0 && ram_wdata.rising)))
        else $error("inactive pixel written with brightness or falling ramp");

    a_clear_covers_all: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clear_busy_reg) |-> ($past(clear_addr_reg) == ADDR_W'(NUM_PIXELS - 1)))
        else $error("clearing pass ended early");

endmodule

[rtl/core/led_twinkle_pixel_engine_unit.sv]
// Top level of the LED twinkle pixel engine: register port, front end and back end.
`timescale 1ns / 1ps

// Usage:
//  pix_in carries one pixel frame update per beat (pixel_index, spawn_hit,
//  color_pick); pix_out returns one colored beat (out_pixel, red, green, blue)
//  per input beat, in order. The APB port holds the four palette colors and
//  the min/max brightness and step; write it only while the engine is idle.
//  Throughput: one beat per cycle once the clearing pass is done and while
//  pix_out.ready stays high, set by the single-write/single-read port of
//  the pixel status RAM (one read-modify-write per beat, with a bypass for
//  the same pixel on consecutive beats). An accepted update goes through
//  the command queue and RAM read, update, multiply, divide-by-255 into
//  the output queue. Reset: config returns to its reset values, then a
//  clearing pass writes every status entry with pix_in.ready low until it
//  ends. Stall: results collect in an 8-beat output queue and updates in
//  a 4-beat command queue; pix_in.ready drops when the command queue is full.
module led_twinkle_pixel_engine_unit #(
    parameter int NUM_PIXELS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lte_in_if.sink      pix_in,
    lte_out_if.source   pix_out
);
    import lte_pkg::*;

    logic [NUM_PALETTE-1:0][23:0] palette_reg;
    logic [7:0]                   min_reg;
    logic [7:0]                   max_reg;
    logic [7:0]                   step_reg;
    logic [2:0]                   reg_idx;
    logic                         wr_en;
    lte_cfg_t                     cfg;
    logic                         cmd_valid;
    lte_cmd_t                     cmd;
    logic                         cmd_pop;
    logic                         clear_busy;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_reg <= {NUM_PALETTE{PALETTE_RESET}};
            min_reg     <= MIN_RESET;
            max_reg     <= MAX_RESET;
            step_reg    <= STEP_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_PALETTE_0:   palette_reg[0] <= pwdata[23:0];
                REG_PALETTE_1:   palette_reg[1] <= pwdata[23:0];
                REG_PALETTE_2:   palette_reg[2] <= pwdata[23:0];
                REG_PALETTE_3:   palette_reg[3] <= pwdata[23:0];
                REG_MIN_BRIGHT:  min_reg        <= pwdata[7:0];
                REG_MAX_BRIGHT:  max_reg        <= pwdata[7:0];
                REG_BRIGHT_STEP: step_reg       <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PALETTE_0:   prdata = {8'd0, palette_reg[0]};
            REG_PALETTE_1:   prdata = {8'd0, palette_reg[1]};
            REG_PALETTE_2:   prdata = {8'd0, palette_reg[2]};
            REG_PALETTE_3:   prdata = {8'd0, palette_reg[3]};
            REG_MIN_BRIGHT:  prdata = {24'd0, min_reg};
            REG_MAX_BRIGHT:  prdata = {24'd0, max_reg};
            REG_BRIGHT_STEP: prdata = {24'd0, step_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        cfg.palette         = palette_reg;
        cfg.start_level     = min_reg;
        cfg.peak_level      = max_reg;
        cfg.brightness_step = step_reg;
    end

    lte_front #(
        .NUM_PIXELS (NUM_PIXELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_in     (pix_in),
        .clear_busy (clear_busy),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    lte_back #(
        .NUM_PIXELS (NUM_PIXELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .clear_busy (clear_busy),
        .pix_out    (pix_out)
    );

endmodule

[bench/led_twinkle_pixel_engine_unit_tb.sv]
// Self-checking bench for the LED twinkle pixel engine: directed frames, then random phases.
`timescale 1ns / 1ps

module led_twinkle_pixel_engine_unit_tb;
    import lte_pkg::*;

    localparam int PIXELS = 256;
    localparam int MAX_GAP = 12;
    localparam int HOLD_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES = 7;
    localparam int FRAMES_PER_PHASE = 240;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    typedef struct {
        bit          is_write;
        logic [2:0]  reg_index;
        logic [31:0] reg_value;
        logic [7:0]  pixel;
        logic        spawn;
        logic [1:0]  pick;
        bit          typed;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lte_in_if  pix_in ();
    lte_out_if pix_out ();

    led_twinkle_pixel_engine_unit #(.NUM_PIXELS(PIXELS)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix_in  (pix_in),
        .pix_out (pix_out)
    );

    // shadow of the engine: registers and per-pixel status
    logic [23:0] palette_shadow [NUM_PALETTE];
    logic [7:0]  min_lvl;
    logic [7:0]  max_lvl;
    logic [7:0]  step_lvl;
    lte_entry_t  twinkle_state [PIXELS];

    lte_pix_t    expected_pixels [$];
    int unsigned mismatches = 0;
    int unsigned dead_cycles = 0;
    bit          quiet_phase = 1'b0;
    bit          hold_pending = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < NUM_PALETTE; i++)
            palette_shadow[i] = PALETTE_RESET;
        min_lvl = MIN_RESET;
        max_lvl = MAX_RESET;
        step_lvl = STEP_RESET;
        for (int i = 0; i < PIXELS; i++)
            twinkle_state[i] = ENTRY_RESET;
    end

    function automatic logic [7:0] dim(input logic [7:0] lvl, input logic [7:0] chan);
        logic [15:0] prod;
        prod = 16'(lvl) * 16'(chan);
        return 8'(prod / 16'd255);
    endfunction

    // one frame of one pixel: update the shadow status, return the colored beat
    function automatic lte_pix_t twinkle_frame(input logic [7:0] px, input logic spawn,
                                               input logic [1:0] pick);
        lte_entry_t e;
        logic [8:0] sum;
        logic [1:0] slot;
        lte_pix_t   res;
        res = '{pixel: px, red: 8'd0, green: 8'd0, blue: 8'd0};
        if (int'(px) >= PIXELS)
            return res;
        e = twinkle_state[px];
        slot = (pick > PICK_MAX) ? PICK_MAX : pick;
        if (!e.active && spawn)
        begin
            e.active = 1'b1;
            e.rising = 1'b1;
            e.brightness = min_lvl;
            e.color = palette_shadow[slot];
        end
        if (e.active)
        begin
            if (e.rising)
            begin
                // wide sum: clamps at the peak instead of wrapping
                sum = 9'(e.brightness) + 9'(step_lvl);
                if (sum >= 9'(max_lvl))
                begin
                    sum = 9'(max_lvl);
                    e.rising = 1'b0;
                end
                e.brightness = sum[7:0];
            end
            else
            begin
                e.brightness = e.brightness -
                               ((e.brightness < step_lvl) ? e.brightness : step_lvl);
                if (e.brightness == 8'd0)
                begin
                    e.rising = 1'b1;
                    e.active = 1'b0;
                end
            end
        end
        twinkle_state[px] = e;
        res.red = dim(e.brightness, e.color[23:16]);
        res.green = dim(e.brightness, e.color[15:8]);
        res.blue = dim(e.brightness, e.color[7:0]);
        return res;
    endfunction

    function automatic script_row_t reg_row(input logic [2:0] idx, input logic [31:0] value);
        script_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.reg_index = idx;
        row.reg_value = value;
        return row;
    endfunction

    function automatic script_row_t frame_row(input logic [7:0] px, input logic spawn,
                                              input logic [1:0] pick);
        script_row_t row;
        row = '{default: '0};
        row.pixel = px;
        row.spawn = spawn;
        row.pick = pick;
        return row;
    endfunction

    function automatic script_row_t known_row(input logic [7:0] px, input logic spawn,
                                              input logic [1:0] pick, input logic [7:0] r,
                                              input logic [7:0] g, input logic [7:0] b);
        script_row_t row;
        row = frame_row(px, spawn, pick);
        row.typed = 1'b1;
        row.red = r;
        row.green = g;
        row.blue = b;
        return row;
    endfunction

    function void check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    // APB write: setup phase, access phase, then idle with psel low
    task automatic program_register(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_PALETTE_0:   palette_shadow[0] = value[23:0];
            REG_PALETTE_1:   palette_shadow[1] = value[23:0];
            REG_PALETTE_2:   palette_shadow[2] = value[23:0];
            REG_PALETTE_3:   palette_shadow[3] = value[23:0];
            REG_MIN_BRIGHT:  min_lvl = value[7:0];
            REG_MAX_BRIGHT:  max_lvl = value[7:0];
            REG_BRIGHT_STEP: step_lvl = value[7:0];
            default: ;
        endcase
    endtask

    task automatic send_frame(input script_row_t row);
        int gap;
        lte_pix_t want;
        gap = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.pixel_index <= row.pixel;
        pix_in.spawn_hit <= row.spawn;
        pix_in.color_pick <= row.pick;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        want = twinkle_frame(row.pixel, row.spawn, row.pick);
        if (row.typed)
        begin
            want.red = row.red;
            want.green = row.green;
            want.blue = row.blue;
        end
        expected_pixels.push_back(want);
    endtask

    // stop offering and wait until every outstanding beat has come back
    task automatic drain_engine();
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random backpressure, one long hold on request
    initial
    begin
        int gap;
        pix_out.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                pix_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
                if (gap > 0)
                begin
                    pix_out.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            pix_out.ready <= 1'b1;
            @(posedge clk);
            while (!pix_out.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        lte_pix_t head;
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat for pixel %0d", $time, pix_out.out_pixel);
            end
            else
            begin
                head = expected_pixels.pop_front();
                check_field("out_pixel", head.pixel, pix_out.out_pixel);
                check_field("red", head.red, pix_out.red);
                check_field("green", head.green, pix_out.green);
                check_field("blue", head.blue, pix_out.blue);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
            dead_cycles <= 0;
        else
            dead_cycles <= dead_cycles + 1;
        if (dead_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        script_row_t script [$];
        script_row_t row;
        logic [7:0]  window_base;
        logic [7:0]  min_v;
        logic [7:0]  max_v;
        logic [7:0]  step_v;

        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        pix_in.valid <= 1'b0;
        pix_in.pixel_index <= '0;
        pix_in.spawn_hit <= 1'b0;
        pix_in.color_pick <= '0;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset palette is 50 per channel, min 1, step 8
        script.push_back(known_row(8'd0, 1'b0, 2'd0, 8'd0, 8'd0, 8'd0));
        script.push_back(known_row(8'd255, 1'b1, 2'd3, 8'd1, 8'd1, 8'd1));
        script.push_back(known_row(8'd255, 1'b1, 2'd0, 8'd3, 8'd3, 8'd3));
        // full-scale settings; the unmapped write must not land anywhere
        script.push_back(reg_row(REG_PALETTE_0, 32'h00FF_FFFF));
        script.push_back(reg_row(REG_PALETTE_1, 32'h0000_0000));
        script.push_back(reg_row(REG_PALETTE_2, 32'h00FF_0000));
        script.push_back(reg_row(REG_PALETTE_3, 32'h005A_A501));
        script.push_back(reg_row(REG_MIN_BRIGHT, 32'd255));
        script.push_back(reg_row(REG_MAX_BRIGHT, 32'd255));
        script.push_back(reg_row(REG_BRIGHT_STEP, 32'd255));
        script.push_back(reg_row(REG_UNMAPPED, 32'hFFFF_FFFF));
        script.push_back(known_row(8'd10, 1'b1, 2'd0, 8'd255, 8'd255, 8'd255));
        script.push_back(known_row(8'd10, 1'b0, 2'd0, 8'd0, 8'd0, 8'd0));
        script.push_back(known_row(8'd11, 1'b1, 2'd1, 8'd0, 8'd0, 8'd0));
        script.push_back(known_row(8'd12, 1'b1, 2'd3, 8'h5A, 8'hA5, 8'h01));
        // 17 + 255 must clamp at 255, not wrap
        script.push_back(known_row(8'd255, 1'b0, 2'd2, 8'd50, 8'd50, 8'd50));
        // zero maximum: peak at 0, gone next frame
        script.push_back(reg_row(REG_MIN_BRIGHT, 32'd0));
        script.push_back(reg_row(REG_MAX_BRIGHT, 32'd0));
        script.push_back(reg_row(REG_BRIGHT_STEP, 32'd0));
        script.push_back(known_row(8'd20, 1'b1, 2'd0, 8'd0, 8'd0, 8'd0));
        script.push_back(known_row(8'd20, 1'b0, 2'd0, 8'd0, 8'd0, 8'd0));
        script.push_back(known_row(8'd20, 1'b0, 2'd1, 8'd0, 8'd0, 8'd0));
        // zero step: stuck at the minimum while rising
        script.push_back(reg_row(REG_MAX_BRIGHT, 32'd200));
        script.push_back(known_row(8'd21, 1'b1, 2'd2, 8'd0, 8'd0, 8'd0));
        script.push_back(known_row(8'd21, 1'b1, 2'd1, 8'd0, 8'd0, 8'd0));
        // short full twinkle on a red pixel
        script.push_back(reg_row(REG_MIN_BRIGHT, 32'd1));
        script.push_back(reg_row(REG_BRIGHT_STEP, 32'd1));
        script.push_back(reg_row(REG_MAX_BRIGHT, 32'd2));
        script.push_back(known_row(8'd21, 1'b0, 2'd0, 8'd1, 8'd0, 8'd0));
        script.push_back(known_row(8'd21, 1'b0, 2'd0, 8'd2, 8'd0, 8'd0));
        script.push_back(known_row(8'd21, 1'b0, 2'd0, 8'd1, 8'd0, 8'd0));
        script.push_back(known_row(8'd21, 1'b0, 2'd0, 8'd0, 8'd0, 8'd0));
        script.push_back(reg_row(REG_MIN_BRIGHT, 32'd128));
        script.push_back(reg_row(REG_BRIGHT_STEP, 32'd100));
        script.push_back(reg_row(REG_MAX_BRIGHT, 32'd255));
        script.push_back(reg_row(REG_PALETTE_0, 32'h0080_FF7F));
        script.push_back(frame_row(8'd30, 1'b1, 2'd0));
        script.push_back(frame_row(8'd30, 1'b0, 2'd3));
        script.push_back(frame_row(8'd30, 1'b1, 2'd2));

        foreach (script[i])
        begin
            if (script[i].is_write)
            begin
                drain_engine();
                program_register(script[i].reg_index, script[i].reg_value);
            end
            else
                send_frame(script[i]);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_engine();
            min_v = 8'($urandom_range(0, 40));
            max_v = 8'($urandom_range(100, 255));
            step_v = 8'($urandom_range(4, 48));
            case (phase)
                1:
                begin
                    step_v = 8'd1;
                    max_v = 8'($urandom_range(8, 24));
                end
                3: min_v = 8'd255;
                5:
                begin
                    step_v = 8'd255;
                    max_v = 8'd255;
                end
                6:
                begin
                    min_v = 8'd0;
                    max_v = 8'd1;
                end
                default: ;
            endcase
            for (int p = 0; p < NUM_PALETTE; p++)
                program_register(REG_PALETTE_0 + 3'(p), $urandom);
            program_register(REG_MIN_BRIGHT, 32'(min_v));
            program_register(REG_MAX_BRIGHT, 32'(max_v));
            program_register(REG_BRIGHT_STEP, 32'(step_v));

            quiet_phase = (phase == 2) || (phase == 4);
            if (phase == 4)
                hold_pending = 1'b1;
            // mostly a small window of pixels so twinkles run their course
            window_base = 8'($urandom_range(0, 255));
            for (int n = 0; n < FRAMES_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    row = frame_row(8'($urandom_range(0, 255)), 1'b0, 2'd0);
                else
                    row = frame_row(8'(window_base + 8'($urandom_range(0, 7))), 1'b0, 2'd0);
                row.spawn = ($urandom_range(0, 3) == 0);
                row.pick = 2'($urandom_range(0, 3));
                send_frame(row);
            end
        end

        drain_engine();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/core/lte_pkg.sv
rtl/core/lte_if.sv
rtl/core/lte_ram.sv
rtl/core/lte_fifo.sv
rtl/core/lte_front.sv
rtl/core/lte_back.sv
rtl/core/led_twinkle_pixel_engine_unit.sv
bench/led_twinkle_pixel_engine_unit_tb.sv
